// ----- rtl/bcs_pkg.sv -----
// shared constants and types for the bad-character substring search block
// no dependencies; compiled first
`default_nettype none

package bcs_pkg;

	localparam int TEXT_DEPTH_DEF    = 2048;
	localparam int PATTERN_DEPTH_DEF = 64;
	localparam int ALPHABET          = 256;
	localparam int POS_W             = 11;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FILL,
		ST_BLD_RD,
		ST_BLD_WR,
		ST_CMP_RD,
		ST_CMP_EQ,
		ST_SH_RD,
		ST_SH_STEP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/bcs_ifs.sv -----
// valid/ready channel interfaces for byte input and search result
// depends on bcs_pkg
`default_nettype none

interface bcs_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, kind, data_byte, last, input ready);
	modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

interface bcs_result_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [bcs_pkg::POS_W-1:0]  match_position;
	logic                       overflow;

	modport source (output valid, found, match_position, overflow, input ready);
	modport sink   (input valid, found, match_position, overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/bad_character_substring_search.sv -----
// bad-character substring search: byte loader, shift table builder and search sequencer
// depends on bcs_pkg and the channel interfaces in bcs_ifs.sv
//
//   channel    | dir | payload                              | transaction
//   byte_ch    | in  | kind, data_byte, last                | one pattern or text byte
//   result_ch  | out | found, match_position, overflow      | one per text ending in last
//
// a pattern or text byte is stored on acceptance if its store has room; a text byte with last set
// also starts a search: a check, presetting all 256 shift table entries, entering the first m-1
// pattern bytes, then a byte compare at each alignment, right to left, plus a shift lookup
// per mismatch (single read port per store).
// byte_ch.ready stays low during the search and while a result waits in the output register.
// reset clears lengths, flags and the sequencer; the stores are not cleared.
`default_nettype none

module bad_character_substring_search #(
	parameter int TEXT_DEPTH    = bcs_pkg::TEXT_DEPTH_DEF,
	parameter int PATTERN_DEPTH = bcs_pkg::PATTERN_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bcs_byte_if.sink      byte_ch,
	bcs_result_if.source  result_ch
);

	localparam int TLW = $clog2(TEXT_DEPTH + 1);
	localparam int PLW = $clog2(PATTERN_DEPTH + 1);
	localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int SW  = PLW;
	localparam int JW  = ((TLW > SW) ? TLW : SW) + 1;

	typedef struct packed {
		logic pat_rd;
		logic pat_rd_k;
		logic txt_rd;
		logic shf_rd;
		logic shf_we;
		logic shf_fill;
	} ctrl_t;

	// stores
	logic [7:0]    pat_mem [PATTERN_DEPTH];
	logic [7:0]    txt_mem [TEXT_DEPTH];
	logic [SW-1:0] shf_mem [bcs_pkg::ALPHABET];

	bcs_pkg::state_t state_q, state_d;
	ctrl_t           ctrl;

	logic [PLW-1:0] plen_q;
	logic           pclosed_q;
	logic [TLW-1:0] tlen_q;
	logic           ovf_q;
	logic [JW-1:0]  t_q;
	logic [JW-1:0]  j_q;
	logic [PAW-1:0] i_q;
	logic [PAW-1:0] k_q;
	logic [7:0]     f_q;
	logic [7:0]     p_rd_q;
	logic [7:0]     t_rd_q;
	logic [SW-1:0]  s_rd_q;

	logic                      out_valid_q;
	logic                      found_q;
	logic [bcs_pkg::POS_W-1:0] pos_q;
	logic                      rovf_q;

	logic           acc;
	logic [PLW-1:0] plen_eff;
	logic           pat_room;
	logic           txt_room;
	logic [PAW-1:0] pat_raddr;
	logic [JW-1:0]  ij;
	logic [7:0]     shf_waddr;
	logic [SW-1:0]  shf_wdata;
	logic           too_short;
	logic           match;
	logic           last_idx;
	logic           bld_done;
	logic [SW:0]    sum;
	logic [SW:0]    step;
	logic [JW-1:0]  j_next;
	logic           beyond;
	logic           res_fire;
	logic           res_found;

	assign acc = byte_ch.valid && byte_ch.ready;
	assign byte_ch.ready = (state_q == bcs_pkg::ST_IDLE) && !out_valid_q;

	// a pattern byte after a closed pattern starts over
	assign plen_eff = pclosed_q ? '0 : plen_q;
	assign pat_room = plen_eff < PLW'(PATTERN_DEPTH);
	assign txt_room = tlen_q < TLW'(TEXT_DEPTH);

	assign pat_raddr = ctrl.pat_rd_k ? k_q : i_q;
	assign ij        = JW'(i_q) + j_q;
	assign shf_waddr = ctrl.shf_fill ? f_q : p_rd_q;
	assign shf_wdata = ctrl.shf_fill ? plen_q : (plen_q - PLW'(k_q) - PLW'(1'b1));

	assign too_short = (plen_q == '0) || (tlen_q == '0) || (JW'(tlen_q) < JW'(plen_q));
	assign match     = p_rd_q == t_rd_q;
	assign last_idx  = i_q == '0;
	assign bld_done  = ((PLW + 1)'(k_q) + (PLW + 1)'(2)) == (PLW + 1)'(plen_q);

	// shift step: max(1, shift - m + 1 + i)
	assign sum    = (SW + 1)'(s_rd_q) + (SW + 1)'(i_q) + (SW + 1)'(1);
	assign step   = (sum > (SW + 1)'(plen_q)) ? (sum - (SW + 1)'(plen_q)) : (SW + 1)'(1);
	assign j_next = j_q + JW'(step);
	assign beyond = j_next > t_q;

	assign res_fire  = ((state_q == bcs_pkg::ST_CHECK) && too_short)
	                || ((state_q == bcs_pkg::ST_CMP_EQ) && match && last_idx)
	                || ((state_q == bcs_pkg::ST_SH_STEP) && beyond);
	assign res_found = (state_q == bcs_pkg::ST_CMP_EQ);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bcs_pkg::ST_IDLE: begin
				if (acc && byte_ch.kind == bcs_pkg::KIND_TEXT && byte_ch.last)
					state_d = bcs_pkg::ST_CHECK;
			end
			bcs_pkg::ST_CHECK: begin
				state_d = too_short ? bcs_pkg::ST_IDLE : bcs_pkg::ST_FILL;
			end
			bcs_pkg::ST_FILL: begin
				if (f_q == 8'hFF)
					state_d = (plen_q == PLW'(1)) ? bcs_pkg::ST_CMP_RD : bcs_pkg::ST_BLD_RD;
			end
			bcs_pkg::ST_BLD_RD: state_d = bcs_pkg::ST_BLD_WR;
			bcs_pkg::ST_BLD_WR: begin
				state_d = bld_done ? bcs_pkg::ST_CMP_RD : bcs_pkg::ST_BLD_RD;
			end
			bcs_pkg::ST_CMP_RD: state_d = bcs_pkg::ST_CMP_EQ;
			bcs_pkg::ST_CMP_EQ: begin
				if (match && last_idx)
					state_d = bcs_pkg::ST_IDLE;
				else if (match)
					state_d = bcs_pkg::ST_CMP_RD;
				else
					state_d = bcs_pkg::ST_SH_RD;
			end
			bcs_pkg::ST_SH_RD: state_d = bcs_pkg::ST_SH_STEP;
			bcs_pkg::ST_SH_STEP: begin
				state_d = beyond ? bcs_pkg::ST_IDLE : bcs_pkg::ST_CMP_RD;
			end
			default: state_d = bcs_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			bcs_pkg::ST_FILL: begin
				ctrl.shf_we   = 1'b1;
				ctrl.shf_fill = 1'b1;
			end
			bcs_pkg::ST_BLD_RD: begin
				ctrl.pat_rd   = 1'b1;
				ctrl.pat_rd_k = 1'b1;
			end
			bcs_pkg::ST_BLD_WR: ctrl.shf_we = 1'b1;
			bcs_pkg::ST_CMP_RD: begin
				ctrl.pat_rd = 1'b1;
				ctrl.txt_rd = 1'b1;
			end
			bcs_pkg::ST_SH_RD: ctrl.shf_rd = 1'b1;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bcs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (acc && byte_ch.kind == bcs_pkg::KIND_PATTERN && pat_room)
			pat_mem[plen_eff[PAW-1:0]] <= byte_ch.data_byte;
		if (ctrl.pat_rd)
			p_rd_q <= pat_mem[pat_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc && byte_ch.kind == bcs_pkg::KIND_TEXT && txt_room)
			txt_mem[tlen_q[TAW-1:0]] <= byte_ch.data_byte;
		if (ctrl.txt_rd)
			t_rd_q <= txt_mem[ij[TAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctrl.shf_we)
			shf_mem[shf_waddr] <= shf_wdata;
		if (ctrl.shf_rd)
			s_rd_q <= shf_mem[t_rd_q];
	end

	// search counters
	always_ff @(posedge clk) begin
		if (state_q == bcs_pkg::ST_CHECK) begin
			f_q <= '0;
			k_q <= '0;
			j_q <= '0;
			i_q <= PAW'(plen_q - PLW'(1'b1));
			t_q <= JW'(tlen_q) - JW'(plen_q);
		end
		if (state_q == bcs_pkg::ST_FILL)
			f_q <= f_q + 8'd1;
		if (state_q == bcs_pkg::ST_BLD_WR)
			k_q <= k_q + PAW'(1'b1);
		if (state_q == bcs_pkg::ST_CMP_EQ && match && !last_idx)
			i_q <= i_q - PAW'(1'b1);
		if (state_q == bcs_pkg::ST_SH_STEP) begin
			j_q <= j_next;
			i_q <= PAW'(plen_q - PLW'(1'b1));
		end
	end

	// lengths and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= '0;
			pclosed_q <= 1'b0;
			tlen_q    <= '0;
			ovf_q     <= 1'b0;
		end else if (res_fire) begin
			tlen_q <= '0;
			ovf_q  <= 1'b0;
		end else if (acc) begin
			if (byte_ch.kind == bcs_pkg::KIND_PATTERN) begin
				plen_q    <= pat_room ? (plen_eff + PLW'(1'b1)) : plen_eff;
				pclosed_q <= byte_ch.last;
				if (!pat_room)
					ovf_q <= 1'b1;
			end else begin
				if (txt_room)
					tlen_q <= tlen_q + TLW'(1'b1);
				else
					ovf_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_fire)
			out_valid_q <= 1'b1;
		else if (result_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			found_q <= res_found;
			pos_q   <= res_found ? bcs_pkg::POS_W'(j_q) : '0;
			rovf_q  <= ovf_q;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.found          = found_q;
	assign result_ch.match_position = pos_q;
	assign result_ch.overflow       = rovf_q;

endmodule

`default_nettype wire

// ----- rtl/bcs_checker.sv -----
// port-level checks for the bad-character substring search block
// depends on bcs_pkg; bound to bad_character_substring_search below
`default_nettype none

module bcs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_kind,
	input logic                      in_last,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      res_found,
	input logic [bcs_pkg::POS_W-1:0] res_pos,
	input logic                      res_ovf
);

	// a waiting result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({res_found, res_pos, res_ovf}))
		else $error("result changed while stalled");

	// no byte transaction while a result waits
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("input ready while result pending");

	// a closing text byte starts the search, input must stall
	a_search_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == bcs_pkg::KIND_TEXT && in_last |=> !in_ready)
		else $error("input ready right after text end");

	// not found reports position zero
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_pos == '0)
		else $error("nonzero position without match");

endmodule

bind bad_character_substring_search bcs_checker u_bcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_ch.valid),
	.in_ready  (byte_ch.ready),
	.in_kind   (byte_ch.kind),
	.in_last   (byte_ch.last),
	.res_valid (result_ch.valid),
	.res_ready (result_ch.ready),
	.res_found (result_ch.found),
	.res_pos   (result_ch.match_position),
	.res_ovf   (result_ch.overflow)
);

`default_nettype wire

// ----- bench/tb.sv -----
// testbench for bad_character_substring_search: random and directed byte streams,
// results checked against a behavioral search predictor held in a small scoreboard class
// depends on bcs_pkg and the channel interfaces in rtl/bcs_ifs.sv

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEXT_DEPTH    = bcs_pkg::TEXT_DEPTH_DEF;
	localparam int PATTERN_DEPTH = bcs_pkg::PATTERN_DEPTH_DEF;
	localparam int RANDOM_ITEMS  = 420;

	typedef logic [7:0] octet_t;

	typedef struct packed {
		logic                      found;
		logic [bcs_pkg::POS_W-1:0] position;
		logic                      overflow;
	} search_report_t;

	class search_tracker;
		octet_t         pat_mem [PATTERN_DEPTH];
		int             pat_len;
		bit             pat_closed;
		octet_t         txt_mem [TEXT_DEPTH];
		int             txt_len;
		bit             dropped;
		search_report_t pending [$];
		int unsigned    errors;

		// first occurrence, bad-character shifts only
		function search_report_t run_search();
			search_report_t r;
			int skip [256];
			int m, n, j, i, step;
			r = '0;
			m = pat_len;
			n = txt_len;
			if (m == 0 || n == 0 || n < m)
				return r;
			foreach (skip[k])
				skip[k] = m;
			for (int k = 0; k + 1 < m; k++)
				skip[pat_mem[k]] = m - k - 1;
			j = 0;
			while (j <= n - m) begin
				i = m - 1;
				while (i >= 0 && pat_mem[i] == txt_mem[i + j])
					i--;
				if (i < 0) begin
					r.found = 1'b1;
					r.position = bcs_pkg::POS_W'(j);
					return r;
				end
				step = skip[txt_mem[i + j]] - m + 1 + i;
				if (step < 1)
					step = 1;
				j += step;
			end
			return r;
		endfunction

		function void note_byte(logic kind, octet_t data, logic last_flag);
			search_report_t r;
			if (kind == bcs_pkg::KIND_PATTERN) begin
				if (pat_closed) begin
					pat_len = 0;
					pat_closed = 1'b0;
				end
				if (pat_len < PATTERN_DEPTH) begin
					pat_mem[pat_len] = data;
					pat_len++;
				end else begin
					dropped = 1'b1;
				end
				if (last_flag)
					pat_closed = 1'b1;
			end else begin
				if (txt_len < TEXT_DEPTH) begin
					txt_mem[txt_len] = data;
					txt_len++;
				end else begin
					dropped = 1'b1;
				end
				if (last_flag) begin
					r = run_search();
					r.overflow = dropped;
					pending.push_back(r);
					txt_len = 0;
					dropped = 1'b0;
				end
			end
		endfunction

		function void check_report(logic found, logic [bcs_pkg::POS_W-1:0] position,
				logic overflow);
			search_report_t want;
			if (pending.size() == 0) begin
				$display("%0t: result found=%0b position=%0d overflow=%0b with none expected",
					$time, found, position, overflow);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (found !== want.found) begin
				$display("%0t: found expected %0b actual %0b", $time, want.found, found);
				errors++;
			end
			if (position !== want.position) begin
				$display("%0t: match_position expected %0d actual %0d",
					$time, want.position, position);
				errors++;
			end
			if (overflow !== want.overflow) begin
				$display("%0t: overflow expected %0b actual %0b", $time, want.overflow, overflow);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bcs_byte_if   byte_bus ();
	bcs_result_if result_bus ();

	bad_character_substring_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_bus),
		.result_ch (result_bus)
	);

	search_tracker tracker = new();
	int            sender_calm;
	int            receiver_calm;
	int unsigned   items_sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// wait draw with occasional runs of back-to-back cycles
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	function automatic void make_bytes(output octet_t q[$], input int len, input octet_t alpha[$]);
		q = {};
		repeat (len) begin
			if (alpha.size() == 0)
				q.push_back(octet_t'($urandom_range(0, 255)));
			else
				q.push_back(alpha[$urandom_range(0, alpha.size() - 1)]);
		end
	endfunction

	// small alphabets make matches likely; an empty one means any byte
	function automatic void pick_alphabet(output octet_t alpha[$]);
		alpha = {};
		if ($urandom_range(0, 3) != 0)
			repeat ($urandom_range(2, 4))
				alpha.push_back(octet_t'($urandom_range(0, 255)));
	endfunction

	task automatic send_byte(logic kind, octet_t data, logic last_flag);
		int gap;
		gap = draw_wait(sender_calm);
		if (gap > 0) begin
			byte_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_bus.valid     <= 1'b1;
		byte_bus.kind      <= kind;
		byte_bus.data_byte <= data;
		byte_bus.last      <= last_flag;
		@(posedge clk);
		while (byte_bus.ready !== 1'b1)
			@(posedge clk);
		tracker.note_byte(kind, data, last_flag);
		items_sent++;
	endtask

	task automatic send_run(logic kind, octet_t q[$], logic close);
		foreach (q[k])
			send_byte(kind, q[k], close && (k == q.size() - 1));
	endtask

	task automatic drain();
		byte_bus.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic directed();
		// text before any pattern: empty pattern
		send_run(bcs_pkg::KIND_TEXT, '{8'h41}, 1'b1);
		send_run(bcs_pkg::KIND_PATTERN, '{8'h00, 8'hFF}, 1'b1);
		send_run(bcs_pkg::KIND_TEXT, '{8'h00, 8'hFF}, 1'b1);
		// text shorter than the pattern
		send_run(bcs_pkg::KIND_TEXT, '{8'hFF}, 1'b1);
		// pattern byte after a closed pattern starts a new one
		send_run(bcs_pkg::KIND_PATTERN, '{8'hAA, 8'h55}, 1'b1);
		send_run(bcs_pkg::KIND_TEXT, '{8'h01, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b1);
		send_run(bcs_pkg::KIND_TEXT, '{8'h55, 8'hAA, 8'h00}, 1'b1);
		// search with the pattern still open, then extend it
		send_run(bcs_pkg::KIND_PATTERN, '{8'h7E, 8'h81}, 1'b0);
		send_run(bcs_pkg::KIND_TEXT, '{8'h7E, 8'h81}, 1'b1);
		send_run(bcs_pkg::KIND_PATTERN, '{8'h7E}, 1'b1);
		send_run(bcs_pkg::KIND_TEXT, '{8'h7E, 8'h81, 8'h7E, 8'h81}, 1'b1);
	endtask

	task automatic store_limits();
		octet_t pat[$], txt[$], any[$];
		int at;
		// full pattern store, match at the far end of the text
		make_bytes(pat, PATTERN_DEPTH, any);
		make_bytes(txt, PATTERN_DEPTH + 40, any);
		at = 40;
		foreach (pat[k])
			txt[at + k] = pat[k];
		send_run(bcs_pkg::KIND_PATTERN, pat, 1'b1);
		send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
		drain();
		// pattern overflow, closing flag rides on a dropped byte
		make_bytes(pat, PATTERN_DEPTH + 2, any);
		send_run(bcs_pkg::KIND_PATTERN, pat, 1'b1);
		make_bytes(txt, 20, any);
		send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
	endtask

	task automatic random_scenario();
		octet_t alpha[$], pat[$], txt[$];
		int pick, m, n, at;
		pick = $urandom_range(0, 99);
		pick_alphabet(alpha);
		pat = {};
		if (pick < 60) begin
			if ($urandom_range(0, 4) != 0) begin
				m = ($urandom_range(0, 19) == 0) ? $urandom_range(9, PATTERN_DEPTH)
				                                 : $urandom_range(1, 6);
				make_bytes(pat, m, alpha);
				send_run(bcs_pkg::KIND_PATTERN, pat, 1'b1);
			end
			n = $urandom_range(1, 24);
			make_bytes(txt, n, alpha);
			if (pat.size() != 0 && n >= pat.size() && $urandom_range(0, 1) == 1) begin
				at = $urandom_range(0, n - pat.size());
				foreach (pat[k])
					txt[at + k] = pat[k];
			end
			send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
		end else if (pick < 70) begin
			m = $urandom_range(2, 10);
			make_bytes(pat, m, alpha);
			send_run(bcs_pkg::KIND_PATTERN, pat, 1'b1);
			make_bytes(txt, $urandom_range(1, m - 1), alpha);
			send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
		end else if (pick < 80) begin
			make_bytes(pat, $urandom_range(1, 5), alpha);
			send_run(bcs_pkg::KIND_PATTERN, pat, 1'b0);
			make_bytes(txt, $urandom_range(1, 20), alpha);
			send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
		end else if (pick < 92) begin
			// loose bytes of either kind with stray last flags
			repeat ($urandom_range(1, 12))
				send_byte(logic'($urandom_range(0, 1)), octet_t'($urandom_range(0, 255)),
					$urandom_range(0, 4) == 0);
		end else if (pick < 95) begin
			make_bytes(pat, $urandom_range(PATTERN_DEPTH + 1, PATTERN_DEPTH + 4), alpha);
			send_run(bcs_pkg::KIND_PATTERN, pat, 1'b1);
			make_bytes(txt, $urandom_range(1, 24), alpha);
			send_run(bcs_pkg::KIND_TEXT, txt, 1'b1);
		end else begin
			drain();
		end
	endtask

	initial begin
		int unsigned base;
		byte_bus.valid     <= 1'b0;
		byte_bus.kind      <= bcs_pkg::KIND_PATTERN;
		byte_bus.data_byte <= 8'h00;
		byte_bus.last      <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		drain();
		store_limits();
		drain();
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS)
			random_scenario();
		drain();
		repeat (64) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side: per draw, ready stays low while the drawn wait runs, then is raised for one slot
	initial begin
		int stall;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(receiver_calm);
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
			if (result_bus.valid === 1'b1)
				tracker.check_report(result_bus.found, result_bus.match_position,
					result_bus.overflow);
		end
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
